>>> hw/rtl/rnw_pkg.sv
// Shared types and constants for the RTP NACK loss window.
package rnw_pkg;

    localparam int WINDOW_SLOTS = 64;
    localparam int SLOT_AW      = $clog2(WINDOW_SLOTS);
    localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
    localparam int SEQ_W        = 16;
    localparam int TIME_W       = 32;
    localparam int MASK_W       = 16;

    localparam logic [SEQ_W-1:0]  SLOTS_SEQ  = SEQ_W'(WINDOW_SLOTS);
    localparam logic [SEQ_W-1:0]  HALF_SEQ   = 16'h8000;

    typedef enum logic [2:0] {
        RES_ADVANCED    = 3'd0,
        RES_LATE_FILLED = 3'd1,
        RES_DUPLICATE   = 3'd2,
        RES_RESYNCED    = 3'd3,
        RES_DROPPED     = 3'd4
    } t_res;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_MISS  = 2'd1,
        SLOT_RECV  = 2'd2
    } t_slot_st;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        t_slot_st         st;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
    } t_in;

    typedef struct packed {
        t_res              status;
        logic              nack_valid;
        logic [SEQ_W-1:0]  lost_first;
        logic [MASK_W-1:0] lost_mask;
    } t_out;

    typedef struct packed {
        logic cap;
        logic dec;
        logic swp;
        logic head;
        logic adv_rd;
        logic adv;
        logic late_rd;
        logic late;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        t_res cls;
        logic sweep_last;
        logic adv_last;
    } t_dp_sts;

endpackage

>>> hw/rtl/rnw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rnw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/rnw_dp.sv
// Datapath: window state, slot RAM, slot walk counters and NACK accumulator.
module rnw_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rnw_pkg::t_dp_cmd                 i_cmd,
    output rnw_pkg::t_dp_sts                 o_sts,
    input  rnw_pkg::t_in                     i_in_data,
    input  logic [rnw_pkg::TIME_W-1:0]       i_sync_timeout,
    output rnw_pkg::t_out                    o_res
);

    logic [rnw_pkg::SEQ_W-1:0]   r_seq;
    logic [rnw_pkg::TIME_W-1:0]  r_now;
    logic [rnw_pkg::SEQ_W-1:0]   r_last_seq;
    logic [rnw_pkg::TIME_W-1:0]  r_last_time;
    logic [rnw_pkg::SLOT_AW-1:0] r_head;
    logic [rnw_pkg::SLOT_AW-1:0] r_new_head;
    logic [rnw_pkg::SLOT_AW-1:0] r_addr;
    logic [rnw_pkg::CNT_W-1:0]   r_k;
    logic [rnw_pkg::CNT_W-1:0]   r_d;
    logic [rnw_pkg::SEQ_W-1:0]   r_fill;
    rnw_pkg::t_res               r_status;
    logic                        r_nvalid;
    logic [rnw_pkg::SEQ_W-1:0]   r_nfirst;
    logic [rnw_pkg::MASK_W-1:0]  r_nmask;

    logic [rnw_pkg::TIME_W-1:0]  elapsed;
    logic [rnw_pkg::SEQ_W-1:0]   fwd;
    logic [rnw_pkg::SEQ_W-1:0]   back;
    rnw_pkg::t_res               cls;
    logic [rnw_pkg::SLOT_AW:0]   late_diff;
    logic [rnw_pkg::SLOT_AW:0]   late_wrap;
    logic [rnw_pkg::SLOT_AW-1:0] late_addr;
    logic [rnw_pkg::SLOT_AW-1:0] addr_next;
    logic [rnw_pkg::SLOT_AW-1:0] head_next;
    logic                        adv_last;
    logic [rnw_pkg::SEQ_W-1:0]   rep_off;

    logic                        ram_wr_en;
    logic [rnw_pkg::SLOT_AW-1:0] ram_wr_addr;
    rnw_pkg::t_slot              ram_wr_slot;
    logic                        ram_rd_en;
    logic [rnw_pkg::SLOT_AW-1:0] ram_rd_addr;
    logic [rnw_pkg::SLOT_W-1:0]  ram_rd_data;
    rnw_pkg::t_slot              rd_slot;

    // classification of the captured packet against the window
    always_comb begin
        elapsed = r_now - r_last_time;
        fwd     = r_seq - r_last_seq;
        back    = r_last_seq - r_seq;
        if (elapsed > i_sync_timeout) begin
            cls = rnw_pkg::RES_RESYNCED;
        end else if (fwd > rnw_pkg::SLOTS_SEQ && fwd < rnw_pkg::HALF_SEQ) begin
            cls = rnw_pkg::RES_RESYNCED;
        end else if (fwd == '0) begin
            cls = rnw_pkg::RES_DUPLICATE;
        end else if (fwd < rnw_pkg::HALF_SEQ) begin
            cls = rnw_pkg::RES_ADVANCED;
        end else if (back >= rnw_pkg::SLOTS_SEQ) begin
            cls = rnw_pkg::RES_DROPPED;
        end else begin
            cls = rnw_pkg::RES_LATE_FILLED;
        end
    end

    // slot behind the head, wrapped into the ring
    always_comb begin
        late_diff = {1'b0, r_head} - {1'b0, back[rnw_pkg::SLOT_AW-1:0]};
        late_wrap = late_diff + (rnw_pkg::SLOT_AW + 1)'(rnw_pkg::WINDOW_SLOTS);
        late_addr = late_diff[rnw_pkg::SLOT_AW] ? late_wrap[rnw_pkg::SLOT_AW-1:0]
                                                 : late_diff[rnw_pkg::SLOT_AW-1:0];
    end

    assign addr_next = (r_addr == rnw_pkg::SLOT_AW'(rnw_pkg::WINDOW_SLOTS - 1))
                       ? '0 : r_addr + 1'b1;
    assign head_next = (r_head == rnw_pkg::SLOT_AW'(rnw_pkg::WINDOW_SLOTS - 1))
                       ? '0 : r_head + 1'b1;

    assign adv_last = (r_k == r_d);
    assign rd_slot  = rnw_pkg::t_slot'(ram_rd_data);
    assign rep_off  = rd_slot.seq - r_nfirst;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_addr;
        ram_wr_slot = '{seq: r_seq, st: rnw_pkg::SLOT_RECV};
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_addr;
        if (i_cmd.swp) begin
            ram_wr_en   = 1'b1;
            ram_wr_slot = '{seq: '0, st: rnw_pkg::SLOT_EMPTY};
        end
        if (i_cmd.head) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_new_head;
        end
        if (i_cmd.adv) begin
            ram_wr_en = 1'b1;
            if (!adv_last) begin
                ram_wr_slot = '{seq: r_fill, st: rnw_pkg::SLOT_MISS};
                ram_rd_en   = 1'b1;
                ram_rd_addr = addr_next;
            end
        end
        if (i_cmd.late) begin
            ram_wr_en = 1'b1;
        end
        if (i_cmd.adv_rd || i_cmd.late_rd) begin
            ram_rd_en = 1'b1;
        end
    end

    rnw_ram #(
        .WIDTH (rnw_pkg::SLOT_W),
        .DEPTH (rnw_pkg::WINDOW_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_slot),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq  <= '0;
            r_last_time <= '0;
            r_head      <= '0;
            r_addr      <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_seq    <= i_in_data.seq;
                r_now    <= i_in_data.now;
                r_nvalid <= 1'b0;
                r_nfirst <= '0;
                r_nmask  <= '0;
            end
            if (i_cmd.dec) begin
                r_status <= cls;
                r_d      <= fwd[rnw_pkg::CNT_W-1:0];
                r_k      <= rnw_pkg::CNT_W'(1);
                r_fill   <= r_last_seq + 1'b1;
                if (cls == rnw_pkg::RES_RESYNCED) begin
                    r_addr     <= '0;
                    r_new_head <= rnw_pkg::SLOT_AW'(r_seq % rnw_pkg::WINDOW_SLOTS);
                end else if (cls == rnw_pkg::RES_LATE_FILLED) begin
                    r_addr <= late_addr;
                end else begin
                    r_addr <= head_next;
                end
            end
            if (i_cmd.swp) begin
                r_addr <= addr_next;
            end
            if (i_cmd.adv) begin
                // report a missing slot before it is overwritten
                if (rd_slot.st == rnw_pkg::SLOT_MISS) begin
                    if (!r_nvalid) begin
                        r_nvalid <= 1'b1;
                        r_nfirst <= rd_slot.seq;
                        r_nmask  <= '0;
                    end else if (rep_off >= 16'd1 && rep_off <= 16'd16) begin
                        r_nmask <= r_nmask | (rnw_pkg::MASK_W'(1) << 4'(rep_off - 1'b1));
                    end
                end
                if (adv_last) begin
                    r_new_head <= r_addr;
                end else begin
                    r_addr <= addr_next;
                    r_k    <= r_k + 1'b1;
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.late) begin
                if (rd_slot.st == rnw_pkg::SLOT_RECV && rd_slot.seq == r_seq) begin
                    r_status <= rnw_pkg::RES_DUPLICATE;
                end
            end
            if (i_cmd.fin) begin
                if (r_status != rnw_pkg::RES_DROPPED) begin
                    r_last_time <= r_now;
                end
                if (r_status == rnw_pkg::RES_ADVANCED || r_status == rnw_pkg::RES_RESYNCED) begin
                    r_last_seq <= r_seq;
                    r_head     <= r_new_head;
                end
            end
        end
    end

    always_comb begin
        o_sts.cls        = cls;
        o_sts.sweep_last = (r_addr == rnw_pkg::SLOT_AW'(rnw_pkg::WINDOW_SLOTS - 1));
        o_sts.adv_last   = adv_last;
    end

    always_comb begin
        o_res.status     = r_status;
        o_res.nack_valid = r_nvalid;
        o_res.lost_first = r_nfirst;
        o_res.lost_mask  = r_nmask;
    end

endmodule

>>> hw/rtl/rnw_ctrl.sv
// Controller: sequences clearing, slot walks and result hand-off.
module rnw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    input  rnw_pkg::t_dp_sts  i_sts,
    output rnw_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_INIT    = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_DECIDE  = 10'b00_0000_0100,
        S_SWEEP   = 10'b00_0000_1000,
        S_HEAD    = 10'b00_0001_0000,
        S_ADV_RD  = 10'b00_0010_0000,
        S_ADV     = 10'b00_0100_0000,
        S_LATE_RD = 10'b00_1000_0000,
        S_LATE    = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.swp = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.dec = 1'b1;
                case (i_sts.cls)
                    rnw_pkg::RES_RESYNCED:    n_state = S_SWEEP;
                    rnw_pkg::RES_ADVANCED:    n_state = S_ADV_RD;
                    rnw_pkg::RES_LATE_FILLED: n_state = S_LATE_RD;
                    default:                  n_state = S_DONE;
                endcase
            end
            S_SWEEP: begin
                o_cmd.swp = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                // place the packet in its home slot
                o_cmd.head = 1'b1;
                n_state    = S_DONE;
            end
            S_ADV_RD: begin
                o_cmd.adv_rd = 1'b1;
                n_state      = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                if (i_sts.adv_last) begin
                    n_state = S_DONE;
                end
            end
            S_LATE_RD: begin
                o_cmd.late_rd = 1'b1;
                n_state       = S_LATE;
            end
            S_LATE: begin
                o_cmd.late = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted beat not followed by classification");

    a_fin_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_out_free)
        else $error("result loaded while output register is occupied");

    a_walk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV && !i_sts.adv_last) |=> (r_state == S_ADV))
        else $error("slot walk left before its last slot");

endmodule

>>> hw/rtl/rtp_nack_window_core.sv
// Top level of the RTP NACK loss window: config register, output register, core.
//
// The work for each packet beat depends on its class: a duplicate or dropped
// packet is only classified; a late packet also reads and rewrites its slot;
// an advance by d slots walks the d slots up to the new head (d at most
// WINDOW_SLOTS); a resync clears all slots and writes the packet's home slot.
// The walk uses the slot RAM, which writes one slot per cycle while its read
// port fetches the next one. After reset a clearing pass over all slots runs
// before the first packet is accepted; configuration writes are taken at any
// time. A finished result waits in an output register, and the next packet
// is accepted while it waits.
module rtp_nack_window_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rnw_pkg::TIME_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  rnw_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output rnw_pkg::t_out                o_out_data
);

    logic [rnw_pkg::TIME_W-1:0] r_sync_timeout;
    logic                       r_out_valid;
    rnw_pkg::t_out              r_out_data;

    rnw_pkg::t_dp_cmd           cmd;
    rnw_pkg::t_dp_sts           sts;
    rnw_pkg::t_out              res;
    logic                       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    rnw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rnw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_in_data      (i_in_data),
        .i_sync_timeout (r_sync_timeout),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_timeout <= rnw_pkg::TIME_W'(1000);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sync_timeout <= i_cfg_data;
            end
            // load a finished result, drop the beat once taken
            if (cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.fin) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
